// ===== rtl/bbc_pkg.sv =====
// bbc_pkg: types, codes and constants of the bracket balance checker
// used by every file of the block but bbc_if; depends on nothing

package bbc_pkg;

   // default stack capacity, in kinds
   localparam int unsigned STACK_DEPTH_DEF = 128;

   // entries of the queue between front and back (a power of two)
   localparam int unsigned QUEUE_DEPTH = 2;

   // bracket characters
   localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28; // (
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7b; // {
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5b; // [
   localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29; // )
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7d; // }
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5d; // ]

   // bracket kinds as kept on the stack
   localparam logic [1:0] KIND_ROUND  = 2'd0;
   localparam logic [1:0] KIND_CURLY  = 2'd1;
   localparam logic [1:0] KIND_SQUARE = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MISMATCH = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_UNCLOSED = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_PUSH = 2'd1,
      OP_POP  = 2'd2
   } op_type;

   // one classified word as it travels from front to back
   typedef struct packed {
      op_type     op;
      logic [1:0] kind;
      logic       last;
   } cmd_type;

   // back-end status seen by the top level
   typedef struct packed {
      logic fire;
      logic last;
      logic empty;
   } back_stat_type;

endpackage

// ===== rtl/bbc_if.sv =====
// bbc_req_if and bbc_rsp_if: valid/ready channels of the checker
// no dependencies

interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface bbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       balanced;
   logic [2:0] status;

   modport source (output valid, output balanced, output status, input ready);
   modport sink   (input valid, input balanced, input status, output ready);
endinterface

// ===== rtl/bbc_front.sv =====
// bbc_front: accepts character words and classifies them into stack commands
// depends on bbc_pkg and bbc_req_if

module bbc_front (
   bbc_req_if.sink          req,
   output logic             enq_valid,
   output bbc_pkg::cmd_type enq_cmd,
   input  logic             enq_ready
);

   logic [1:0]      kind;
   bbc_pkg::op_type op;

   always_comb begin
      case (req.char_code)
         bbc_pkg::CHAR_OPEN_ROUND: begin
            op   = bbc_pkg::OP_PUSH;
            kind = bbc_pkg::KIND_ROUND;
         end
         bbc_pkg::CHAR_OPEN_CURLY: begin
            op   = bbc_pkg::OP_PUSH;
            kind = bbc_pkg::KIND_CURLY;
         end
         bbc_pkg::CHAR_OPEN_SQUARE: begin
            op   = bbc_pkg::OP_PUSH;
            kind = bbc_pkg::KIND_SQUARE;
         end
         bbc_pkg::CHAR_CLOSE_ROUND: begin
            op   = bbc_pkg::OP_POP;
            kind = bbc_pkg::KIND_ROUND;
         end
         bbc_pkg::CHAR_CLOSE_CURLY: begin
            op   = bbc_pkg::OP_POP;
            kind = bbc_pkg::KIND_CURLY;
         end
         bbc_pkg::CHAR_CLOSE_SQUARE: begin
            op   = bbc_pkg::OP_POP;
            kind = bbc_pkg::KIND_SQUARE;
         end
         default: begin
            op   = bbc_pkg::OP_NONE;
            kind = bbc_pkg::KIND_NONE;
         end
      endcase
   end

   assign enq_valid    = req.valid;
   assign enq_cmd.op   = op;
   assign enq_cmd.kind = kind;
   assign enq_cmd.last = req.last;
   assign req.ready    = enq_ready;

endmodule

// ===== rtl/bbc_queue.sv =====
// bbc_queue: short fifo of classified commands between front and back
// depends on bbc_pkg

module bbc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             enq_valid,
   input  bbc_pkg::cmd_type enq_cmd,
   output logic             enq_ready,
   output logic             deq_valid,
   output bbc_pkg::cmd_type deq_cmd,
   input  logic             deq_ready
);

   localparam int unsigned PW = $clog2(bbc_pkg::QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(bbc_pkg::QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(bbc_pkg::QUEUE_DEPTH);

   bbc_pkg::cmd_type slot_ff [bbc_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_enq, do_deq;

   assign enq_ready = (count_ff != FULL_COUNT);
   assign deq_valid = (count_ff != '0);
   assign deq_cmd   = slot_ff[rd_ptr_ff];
   assign do_enq    = enq_valid && enq_ready;
   assign do_deq    = deq_valid && deq_ready;

   always_comb begin
      wr_ptr_in = do_enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq && !do_deq) begin
         count_in = count_ff + 1'b1;
      end else if (!do_enq && do_deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         slot_ff[wr_ptr_ff] <= enq_cmd;
      end
   end

endmodule

// ===== rtl/bbc_back.sv =====
// bbc_back: bracket stack, sticky failure code and result register
// depends on bbc_pkg and bbc_rsp_if

module bbc_back #(
   parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   deq_valid,
   input  bbc_pkg::cmd_type       deq_cmd,
   output logic                   deq_ready,
   bbc_rsp_if.source              rsp,
   output bbc_pkg::back_stat_type stat
);

   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned IW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] DEPTH_COUNT = CW'(STACK_DEPTH);

   logic [1:0]          stack_mem [STACK_DEPTH];
   logic [CW-1:0]       count_ff, count_in;
   bbc_pkg::status_type fail_ff, fail_in;
   logic [1:0]          top_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                balanced_ff, balanced_in;
   bbc_pkg::status_type status_ff, status_in;

   logic          out_free, fire, wr_en;
   logic [CW-1:0] rd_count;
   logic [IW-1:0] rd_addr, wr_addr;
   bbc_pkg::status_type code;
   logic [CW-1:0] count_step;

   // a non-last word never waits on the result register
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign deq_ready = !deq_cmd.last || out_free;
   assign fire      = deq_valid && deq_ready;
   assign wr_addr   = count_ff[IW-1:0];

   always_comb begin
      fail_in    = fail_ff;
      count_step = count_ff;
      wr_en      = 1'b0;
      rd_count   = count_ff - 1'b1;
      if (fire && fail_ff == bbc_pkg::ST_OK) begin
         case (deq_cmd.op)
            bbc_pkg::OP_PUSH: begin
               if (count_ff == DEPTH_COUNT) begin
                  fail_in = bbc_pkg::ST_OVERFLOW;
               end else begin
                  wr_en      = 1'b1;
                  count_step = count_ff + 1'b1;
                  rd_count   = count_ff;
               end
            end
            bbc_pkg::OP_POP: begin
               if (count_ff == '0) begin
                  fail_in = bbc_pkg::ST_EMPTY;
               end else if (top_ff == deq_cmd.kind) begin
                  count_step = count_ff - 1'b1;
                  rd_count   = count_ff - 2'd2;
               end else begin
                  fail_in = bbc_pkg::ST_MISMATCH;
               end
            end
            default: begin
            end
         endcase
      end
      rd_addr = rd_count[IW-1:0];

      code = fail_in;
      if (fail_in == bbc_pkg::ST_OK && count_step != '0) begin
         code = bbc_pkg::ST_UNCLOSED;
      end

      count_in     = count_step;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      balanced_in  = balanced_ff;
      status_in    = status_ff;
      if (fire && deq_cmd.last) begin
         count_in     = '0;
         fail_in      = bbc_pkg::ST_OK;
         rsp_valid_in = 1'b1;
         balanced_in  = (code == bbc_pkg::ST_OK);
         status_in    = code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fail_ff      <= bbc_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      balanced_ff <= balanced_in;
      status_ff   <= status_in;
   end

   // stack memory: one write, one registered read of the next top
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= deq_cmd.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         top_ff <= deq_cmd.kind;
      end else begin
         top_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.balanced = balanced_ff;
   assign rsp.status   = status_ff;

   assign stat.fire  = fire;
   assign stat.last  = deq_cmd.last;
   assign stat.empty = (count_ff == '0);

endmodule

// ===== rtl/bracket_balance_checker.sv =====
// bracket_balance_checker: top level of the bracket balance checker
// depends on bbc_pkg, bbc_if, bbc_front, bbc_queue and bbc_back

// Checks strings for balanced round, curly and square brackets, one
// character word per cycle on the req channel, with last set on the final
// character of each string. For every word with last set, one word leaves on
// the rsp channel: balanced is 1 when status is ok; status is 0 ok, 1 a
// closing bracket that does not match the open one, 2 a closing bracket on an
// empty stack, 3 brackets left open at the end, 4 more than STACK_DEPTH open
// brackets at once. The first failure of a string wins; the stack and the
// failure are cleared after its last character. The block sustains one
// character per cycle unless a last character waits on an untaken result:
// the front classifies each character into a push, pop or no-op and hands
// it through a two-entry queue to the back, which applies one push or pop
// per cycle to the stack memory and keeps the top of stack in a register
// read ahead from the memory's single read port. A result is registered once
// its last character leaves the queue, and it waits in an output register
// while further characters keep flowing; only a second last character
// stalls behind an untaken result. No clearing pass after reset.

module bracket_balance_checker #(
   parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bbc_req_if.sink   req,
   bbc_rsp_if.source rsp
);

   // front to queue
   logic                   enq_valid;
   logic                   enq_ready;
   bbc_pkg::cmd_type       enq_cmd;

   // queue to back
   logic                   deq_valid;
   logic                   deq_ready;
   bbc_pkg::cmd_type       deq_cmd;

   // back-end status for checks
   bbc_pkg::back_stat_type back_stat;

   // classify characters into stack commands
   bbc_front u_front (
      .req       (req),
      .enq_valid (enq_valid),
      .enq_cmd   (enq_cmd),
      .enq_ready (enq_ready)
   );

   // decouple acceptance from stack work
   bbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_cmd   (enq_cmd),
      .enq_ready (enq_ready),
      .deq_valid (deq_valid),
      .deq_cmd   (deq_cmd),
      .deq_ready (deq_ready)
   );

   // stack engine and result register
   bbc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .deq_valid (deq_valid),
      .deq_cmd   (deq_cmd),
      .deq_ready (deq_ready),
      .rsp       (rsp),
      .stat      (back_stat)
   );

`ifndef SYNTHESIS
   // a finished string always leaves an empty stack behind
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      back_stat.fire && back_stat.last |=> back_stat.empty)
      else $error("stack not cleared after last character");

   // the pass flag agrees with the status code
   a_balanced_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.balanced == (rsp.status == bbc_pkg::ST_OK)))
      else $error("balanced flag disagrees with status");

   // a last word that fires always produces a result next cycle
   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      back_stat.fire && back_stat.last |=> rsp.valid)
      else $error("no result after last character");
`endif

endmodule

// ===== tb/bracket_balance_checker_test.sv =====
`timescale 1ns / 100ps
// bracket_balance_checker_test: self-checking testbench of the bracket balance checker
// depends on bbc_pkg, bbc_if and bracket_balance_checker

module bracket_balance_checker_test;
   import bbc_pkg::*;

   localparam int unsigned DEPTH = STACK_DEPTH_DEF;
   // the directed table sends about 535 words on its own
   localparam int unsigned RANDOM_WORDS = 365;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned IDLE_PCT = 31;
   localparam int unsigned REPORT_MAX = 10;

   // opening and closing characters indexed by kind
   localparam logic [7:0] OPEN_CHARS [3] = '{CHAR_OPEN_ROUND, CHAR_OPEN_CURLY, CHAR_OPEN_SQUARE};
   localparam logic [7:0] CLOSE_CHARS [3] =
      '{CHAR_CLOSE_ROUND, CHAR_CLOSE_CURLY, CHAR_CLOSE_SQUARE};

   typedef struct packed {
      logic       balanced;
      status_type status;
   } verdict_type;

   // one directed row: a character repeated reps times, last and the typed
   // verdict apply to the final repeat only
   typedef struct packed {
      logic [7:0]  ch;
      logic        last;
      int unsigned reps;
      logic        typed;
      status_type  status;
   } plan_row_type;

   localparam int unsigned PLAN_ROWS = 28;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // close on an empty stack right after reset
      '{CHAR_CLOSE_ROUND,  1'b1, 1,         1'b1, ST_EMPTY},
      // strings with no brackets at all, byte extremes among them
      '{8'h61,             1'b1, 1,         1'b1, ST_OK},
      '{8'h00,             1'b1, 1,         1'b1, ST_OK},
      '{8'hff,             1'b1, 1,         1'b1, ST_OK},
      // simple round pair
      '{CHAR_OPEN_ROUND,   1'b0, 1,         1'b0, ST_OK},
      '{CHAR_CLOSE_ROUND,  1'b1, 1,         1'b1, ST_OK},
      // nested curly and square
      '{CHAR_OPEN_CURLY,   1'b0, 1,         1'b0, ST_OK},
      '{CHAR_OPEN_SQUARE,  1'b0, 1,         1'b0, ST_OK},
      '{CHAR_CLOSE_SQUARE, 1'b0, 1,         1'b0, ST_OK},
      '{CHAR_CLOSE_CURLY,  1'b1, 1,         1'b0, ST_OK},
      // wrong kind closes
      '{CHAR_OPEN_CURLY,   1'b0, 1,         1'b0, ST_OK},
      '{CHAR_CLOSE_SQUARE, 1'b1, 1,         1'b1, ST_MISMATCH},
      // left open at the end
      '{CHAR_OPEN_SQUARE,  1'b0, 1,         1'b0, ST_OK},
      '{CHAR_OPEN_ROUND,   1'b1, 1,         1'b1, ST_UNCLOSED},
      // stack full, one more open overflows
      '{CHAR_OPEN_ROUND,   1'b0, DEPTH,     1'b0, ST_OK},
      '{CHAR_OPEN_SQUARE,  1'b1, 1,         1'b1, ST_OVERFLOW},
      // overflow stays sticky through a matching close
      '{CHAR_OPEN_ROUND,   1'b0, DEPTH,     1'b0, ST_OK},
      '{CHAR_OPEN_ROUND,   1'b0, 1,         1'b0, ST_OK},
      '{CHAR_CLOSE_ROUND,  1'b1, 1,         1'b1, ST_OVERFLOW},
      // fill to capacity and drain back to empty
      '{CHAR_OPEN_ROUND,   1'b0, DEPTH,     1'b0, ST_OK},
      '{CHAR_CLOSE_ROUND,  1'b0, DEPTH - 1, 1'b0, ST_OK},
      '{CHAR_CLOSE_ROUND,  1'b1, 1,         1'b1, ST_OK},
      // empty-stack failure is sticky over a later good pair
      '{CHAR_CLOSE_SQUARE, 1'b0, 1,         1'b0, ST_OK},
      '{CHAR_OPEN_ROUND,   1'b0, 1,         1'b0, ST_OK},
      '{CHAR_CLOSE_ROUND,  1'b1, 1,         1'b1, ST_EMPTY},
      // filler between a pair
      '{CHAR_OPEN_SQUARE,  1'b0, 1,         1'b0, ST_OK},
      '{8'h78,             1'b0, 1,         1'b0, ST_OK},
      '{CHAR_CLOSE_SQUARE, 1'b1, 1,         1'b0, ST_OK}
   };

   logic clock = 1'b0;
   logic reset;

   bbc_req_if req_if ();
   bbc_rsp_if rsp_if ();

   bracket_balance_checker #(
      .STACK_DEPTH(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   always #5 clock = ~clock;

   // typed verdict travels with the word it belongs to
   logic       typed_now;
   status_type typed_status;

   // predictor state: open kinds, their count and the first failure
   logic [1:0]  open_kinds [DEPTH];
   int unsigned open_count;
   status_type  first_fail;

   verdict_type verdict_q [$];
   int unsigned fault_count = 0;

   // both sides stop idling while steady is set
   bit steady = 1'b0;
   bit hold_rsp_req = 1'b0;

   logic [7:0] text_q [$];

   // one character through the predictor; returns a verdict on the last one
   task automatic balance_step(input logic [7:0] c, input logic l, output bit produced,
                               output verdict_type v);
      logic [1:0] ok;
      logic [1:0] ck;
      status_type code;
      ok = KIND_NONE;
      ck = KIND_NONE;
      produced = 1'b0;
      v = '0;
      case (c)
         CHAR_OPEN_ROUND:   ok = KIND_ROUND;
         CHAR_OPEN_CURLY:   ok = KIND_CURLY;
         CHAR_OPEN_SQUARE:  ok = KIND_SQUARE;
         CHAR_CLOSE_ROUND:  ck = KIND_ROUND;
         CHAR_CLOSE_CURLY:  ck = KIND_CURLY;
         CHAR_CLOSE_SQUARE: ck = KIND_SQUARE;
         default: ;
      endcase
      // after the first failure the rest of the string is ignored
      if (first_fail == ST_OK) begin
         if (ok != KIND_NONE) begin
            if (open_count >= DEPTH) begin
               first_fail = ST_OVERFLOW;
            end else begin
               open_kinds[open_count] = ok;
               open_count++;
            end
         end else if (ck != KIND_NONE) begin
            if (open_count == 0) begin
               first_fail = ST_EMPTY;
            end else if (open_kinds[open_count - 1] == ck) begin
               open_count--;
            end else begin
               first_fail = ST_MISMATCH;
            end
         end
      end
      if (l) begin
         code = first_fail;
         if (code == ST_OK && open_count != 0) begin
            code = ST_UNCLOSED;
         end
         v.balanced = (code == ST_OK);
         v.status = code;
         produced = 1'b1;
         open_count = 0;
         first_fail = ST_OK;
      end
   endtask

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_MAX) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // predict on every accepted input word, then check every accepted result;
   // both in one process so that a word and a result at the same edge keep order
   always @(posedge clock) begin
      bit          produced;
      verdict_type v;
      verdict_type want;
      if (reset) begin
         open_count = 0;
         first_fail = ST_OK;
      end else begin
         if (req_if.valid && req_if.ready) begin
            balance_step(req_if.char_code, req_if.last, produced, v);
            if (produced) begin
               // directed rows with a verdict typed in override the predictor
               if (typed_now) begin
                  v.status = typed_status;
                  v.balanced = (typed_status == ST_OK);
               end
               verdict_q.push_back(v);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (verdict_q.size() == 0) begin
               note_fault($sformatf("unexpected result balanced=%0b status=%0d",
                                    rsp_if.balanced, rsp_if.status));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_if.balanced !== want.balanced || rsp_if.status !== want.status) begin
                  note_fault($sformatf(
                     "mismatch: expected balanced=%0b status=%0d, got balanced=%0b status=%0d",
                     want.balanced, want.status, rsp_if.balanced, rsp_if.status));
               end
            end
         end
      end
   end

   // offer one word and wait until it is taken; random gaps ahead of it
   task automatic send_char(input logic [7:0] c, input logic l, input logic typed,
                            input status_type st);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.char_code <= c;
      req_if.last <= l;
      typed_now <= typed;
      typed_status <= st;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
   endtask

   // one random string into text_q: mostly well formed with filler, some
   // pure noise, some broken; a deep one opens DEPTH - 1 to DEPTH + 1 brackets
   task automatic build_text(input bit deep);
      logic [1:0]  kinds [$];
      int unsigned shape;
      int unsigned pick;
      logic [1:0]  k;
      text_q = {};
      shape = $urandom_range(99);
      if (deep) begin
         repeat ($urandom_range(DEPTH - 1, DEPTH + 1)) begin
            k = 2'($urandom_range(2));
            kinds.push_back(k);
            text_q.push_back(OPEN_CHARS[k]);
         end
      end else if (shape < 10) begin
         repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(1, 16)) begin
            pick = $urandom_range(9);
            if (pick < 4) begin
               k = 2'($urandom_range(2));
               kinds.push_back(k);
               text_q.push_back(OPEN_CHARS[k]);
            end else if (pick < 7 && kinds.size() != 0) begin
               text_q.push_back(CLOSE_CHARS[kinds.pop_back()]);
            end else if ($urandom_range(4) == 0) begin
               text_q.push_back(8'($urandom_range(255)));
            end else begin
               text_q.push_back(8'h61 + 8'($urandom_range(25)));
            end
         end
      end
      while (kinds.size() != 0) begin
         text_q.push_back(CLOSE_CHARS[kinds.pop_back()]);
      end
      // break about one string in five
      if (!deep && shape >= 80) begin
         case (shape % 3)
            0: text_q[$urandom_range(text_q.size() - 1)] = $urandom_range(1) ?
                  OPEN_CHARS[$urandom_range(2)] : CLOSE_CHARS[$urandom_range(2)];
            1: text_q.insert($urandom_range(text_q.size()), CLOSE_CHARS[$urandom_range(2)]);
            default: void'(text_q.pop_back());
         endcase
      end
      if (text_q.size() == 0) begin
         text_q.push_back(OPEN_CHARS[$urandom_range(2)]);
      end
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp_req = 1'b0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // hard limit on the run
   initial begin
      #2_000_000;
      $display("** bracket_balance_checker: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned strings;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.char_code <= '0;
      req_if.last <= 1'b0;
      typed_now <= 1'b0;
      typed_status <= ST_OK;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < PLAN_ROWS; r++) begin
         for (int unsigned n = 0; n < PLAN[r].reps; n++) begin
            send_char(PLAN[r].ch, PLAN[r].last && n == PLAN[r].reps - 1,
                      PLAN[r].typed && n == PLAN[r].reps - 1, PLAN[r].status);
         end
      end

      // random strings; enough of them to reach the hold-off and the drain
      sent = 0;
      strings = 0;
      while (sent < RANDOM_WORDS || strings <= 22) begin
         steady = (strings >= 8 && strings < 16);
         // hold the receiver off while strings keep coming, so the block backs up
         if (strings == 18) begin
            hold_rsp_req = 1'b1;
         end
         // let the block drain completely once
         if (strings == 22) begin
            req_if.valid <= 1'b0;
            do begin
               @(posedge clock);
            end while (verdict_q.size() != 0);
         end
         build_text(strings == 5);
         foreach (text_q[i]) begin
            send_char(text_q[i], i == text_q.size() - 1, 1'b0, ST_OK);
         end
         sent += text_q.size();
         strings++;
      end
      steady = 1'b0;
      req_if.valid <= 1'b0;

      // drain, then wait quietly to catch stray results
      for (int w = 0; w < 20000 && verdict_q.size() != 0; w++) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
      if (verdict_q.size() != 0) begin
         note_fault($sformatf("%0d results never arrived", verdict_q.size()));
      end
      if (fault_count == 0) begin
         $display("** bracket_balance_checker: PASSED **");
      end else begin
         $display("** bracket_balance_checker: FAILED **");
      end
      $finish;
   end

endmodule
